// ----- design/scpu_pkg.sv -----
package scpu_pkg;

  localparam int NUM_REGS        = 32;
  localparam int STACK_DEPTH     = 1024;
  localparam int RETURN_REG_CODE = 31;

  localparam int REG_AW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int SP_W      = $clog2(STACK_DEPTH);
  localparam int CLEAR_LEN = (STACK_DEPTH > NUM_REGS) ? STACK_DEPTH : NUM_REGS;
  localparam int CLR_W     = $clog2(CLEAR_LEN);

  localparam logic [31:0] PORT_INT  = 32'd12288;
  localparam logic [31:0] PORT_CHAR = 32'd12289;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_LDI  = 4'd1,
    OP_ADDI = 4'd2,
    OP_SUBI = 4'd3,
    OP_MOV  = 4'd4,
    OP_PUSH = 4'd5,
    OP_POP  = 4'd6,
    OP_STR  = 4'd7,
    OP_EXIT = 4'd8,
    OP_SLT  = 4'd9,
    OP_BZ   = 4'd10,
    OP_BNZ  = 4'd11,
    OP_CALL = 4'd12,
    OP_RET  = 4'd13
  } opcode_t;

  typedef enum logic [1:0] {
    PRINT_NONE = 2'd0,
    PRINT_INT  = 2'd1,
    PRINT_CHAR = 2'd2
  } print_kind_t;

  typedef enum logic [1:0] {
    RUN_OK      = 2'd0,
    RUN_EXIT    = 2'd1,
    RUN_ILLEGAL = 2'd2
  } run_status_t;

  typedef struct packed {
    logic [3:0]         mode;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg;
    logic signed [15:0] imm_value;
  } instr_t;

  typedef struct packed {
    logic [15:0]        next_fetch;
    logic [1:0]         print_kind;
    logic signed [31:0] print_value;
    logic [1:0]         run_status;
  } result_t;

endpackage

// ----- design/stack_cpu_execute_unit.sv -----
// Execute stage of a small stack machine. One instruction is taken per cycle when not stalled, and
// its result (next fetch address, console output, run status) comes out of the result register: the
// register file and stack memory are read into a register as the instruction is accepted, with the
// write of the instruction ahead of it forwarded, and the instruction then executes in one
// pass into the result register. The result register lets a new instruction be accepted while
// an earlier result is still stalled. After reset the stack memory and register file are
// cleared at one entry per cycle over CLEAR_LEN entries (1024 as configured); no
// instruction is accepted during that pass.
module stack_cpu_execute_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            instr_valid,
  output logic            instr_stall,
  input  scpu_pkg::instr_t  instr,
  output logic            result_valid,
  input  logic            result_stall,
  output scpu_pkg::result_t result
);

  function automatic logic reg_ok(input logic [4:0] n);
    reg_ok = int'(n) < scpu_pkg::NUM_REGS;
  endfunction

  function automatic logic [scpu_pkg::SP_W-1:0] sp_inc(input logic [scpu_pkg::SP_W-1:0] p);
    sp_inc = (p == scpu_pkg::SP_W'(scpu_pkg::STACK_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [scpu_pkg::SP_W-1:0] sp_dec(input logic [scpu_pkg::SP_W-1:0] p);
    sp_dec = (p == '0) ? scpu_pkg::SP_W'(scpu_pkg::STACK_DEPTH - 1) : p - 1'b1;
  endfunction

  logic [31:0] rf [scpu_pkg::NUM_REGS];
  logic [31:0] stack_mem [scpu_pkg::STACK_DEPTH];

  logic                        clearing;
  logic [scpu_pkg::CLR_W-1:0]  clr_cnt;

  logic                        s1_valid;
  scpu_pkg::instr_t            s1;
  logic [31:0]                 rd_dst;
  logic [31:0]                 rd_src;
  logic [31:0]                 rd_stack;

  logic [15:0]                 pc;
  logic [15:0]                 pc_next;
  logic [scpu_pkg::SP_W-1:0]   sp;
  logic [scpu_pkg::SP_W-1:0]   sp_next;
  logic [15:0]                 ra;
  logic [15:0]                 ra_next;
  logic                        halted;
  logic                        halted_next;

  logic                        res_valid;
  scpu_pkg::result_t           res;
  scpu_pkg::result_t           res_next;

  logic                        advance;
  logic                        accept;
  logic                        exec_fire;

  logic                        rf_we;
  logic [31:0]                 rf_wdata;
  logic                        rf_we_f;
  logic [scpu_pkg::REG_AW-1:0] rf_widx;
  logic                        st_we;
  logic [31:0]                 st_wdata;
  logic                        st_we_f;

  logic [31:0]                 imm32;
  logic [31:0]                 st_addr;
  logic [scpu_pkg::SP_W-1:0]   rd_sp_base;
  logic [scpu_pkg::SP_W-1:0]   rd_sp_addr;
  logic [scpu_pkg::REG_AW-1:0] idx_dst;
  logic [scpu_pkg::REG_AW-1:0] idx_src;

  assign advance     = !res_valid || !result_stall;
  assign instr_stall = clearing || (s1_valid && !advance);
  assign accept      = instr_valid && !instr_stall;
  assign exec_fire   = s1_valid && advance;

  assign result_valid = res_valid;
  assign result       = res;

  // execute
  assign imm32   = {{16{s1.imm_value[15]}}, s1.imm_value};
  assign st_addr = rd_src + imm32;

  always_comb begin
    pc_next     = pc;
    sp_next     = sp;
    ra_next     = ra;
    halted_next = halted;
    rf_we       = 1'b0;
    rf_wdata    = '0;
    st_we       = 1'b0;
    st_wdata    = '0;
    res_next    = '0;
    res_next.run_status = scpu_pkg::RUN_EXIT;
    if (!halted) begin
      pc_next = pc + 16'd1;
      res_next.run_status = scpu_pkg::RUN_OK;
      case (s1.mode)
        scpu_pkg::OP_ADD: begin
          rf_we    = 1'b1;
          rf_wdata = rd_dst + rd_src;
        end
        scpu_pkg::OP_LDI: begin
          rf_we    = 1'b1;
          rf_wdata = imm32;
        end
        scpu_pkg::OP_ADDI: begin
          rf_we    = 1'b1;
          rf_wdata = rd_dst + imm32;
        end
        scpu_pkg::OP_SUBI: begin
          rf_we    = 1'b1;
          rf_wdata = rd_dst - imm32;
        end
        scpu_pkg::OP_MOV: begin
          rf_we    = 1'b1;
          rf_wdata = rd_src;
        end
        scpu_pkg::OP_PUSH: begin
          st_we    = 1'b1;
          st_wdata = (int'(s1.dest_reg) == scpu_pkg::RETURN_REG_CODE) ? {16'd0, ra} : rd_dst;
          sp_next  = sp_inc(sp);
        end
        scpu_pkg::OP_POP: begin
          sp_next = sp_dec(sp);
          if (int'(s1.dest_reg) == scpu_pkg::RETURN_REG_CODE) begin
            ra_next = rd_stack[15:0];
          end else begin
            rf_we    = 1'b1;
            rf_wdata = rd_stack;
          end
        end
        scpu_pkg::OP_STR: begin
          if (st_addr == scpu_pkg::PORT_INT) begin
            res_next.print_kind  = scpu_pkg::PRINT_INT;
            res_next.print_value = rd_dst;
          end else if (st_addr == scpu_pkg::PORT_CHAR) begin
            res_next.print_kind  = scpu_pkg::PRINT_CHAR;
            res_next.print_value = {24'd0, rd_dst[7:0]};
          end
        end
        scpu_pkg::OP_EXIT: begin
          halted_next         = 1'b1;
          res_next.run_status = scpu_pkg::RUN_EXIT;
        end
        scpu_pkg::OP_SLT: begin
          rf_we    = 1'b1;
          rf_wdata = ($signed(rd_src) < $signed(imm32)) ? 32'd1 : 32'd0;
        end
        scpu_pkg::OP_BZ: begin
          if (rd_dst == '0) pc_next = s1.imm_value;
        end
        scpu_pkg::OP_BNZ: begin
          if (rd_dst != '0) pc_next = s1.imm_value;
        end
        scpu_pkg::OP_CALL: begin
          ra_next = pc + 16'd1;
          pc_next = s1.imm_value;
        end
        scpu_pkg::OP_RET: begin
          pc_next = ra;
        end
        default: begin
          halted_next         = 1'b1;
          res_next.run_status = scpu_pkg::RUN_ILLEGAL;
        end
      endcase
    end
    res_next.next_fetch = pc_next;
  end

  assign rf_we_f = exec_fire && rf_we && reg_ok(s1.dest_reg);
  assign rf_widx = scpu_pkg::REG_AW'(s1.dest_reg);
  assign st_we_f = exec_fire && st_we;

  // read addresses for the incoming instruction see the state after the one executing now
  assign rd_sp_base = s1_valid ? sp_next : sp;
  assign rd_sp_addr = sp_dec(rd_sp_base);
  assign idx_dst    = scpu_pkg::REG_AW'(instr.dest_reg);
  assign idx_src    = scpu_pkg::REG_AW'(instr.src_reg);

  // register file
  always_ff @(posedge clk) begin
    if (clearing) begin
      if (int'(clr_cnt) < scpu_pkg::NUM_REGS) begin
        rf[scpu_pkg::REG_AW'(clr_cnt)] <= '0;
      end
    end else if (rf_we_f) begin
      rf[rf_widx] <= rf_wdata;
    end
    if (accept) begin
      if (!reg_ok(instr.dest_reg)) begin
        rd_dst <= '0;
      end else if (rf_we_f && rf_widx == idx_dst) begin
        rd_dst <= rf_wdata;
      end else begin
        rd_dst <= rf[idx_dst];
      end
      if (!reg_ok(instr.src_reg)) begin
        rd_src <= '0;
      end else if (rf_we_f && rf_widx == idx_src) begin
        rd_src <= rf_wdata;
      end else begin
        rd_src <= rf[idx_src];
      end
    end
  end

  // stack memory
  always_ff @(posedge clk) begin
    if (clearing) begin
      if (int'(clr_cnt) < scpu_pkg::STACK_DEPTH) begin
        stack_mem[scpu_pkg::SP_W'(clr_cnt)] <= '0;
      end
    end else if (st_we_f) begin
      stack_mem[sp] <= st_wdata;
    end
    if (accept) begin
      if (st_we_f && sp == rd_sp_addr) begin
        rd_stack <= st_wdata;
      end else begin
        rd_stack <= stack_mem[rd_sp_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= instr;
    end
    if (exec_fire) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      pc        <= '0;
      sp        <= '0;
      ra        <= '0;
      halted    <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (int'(clr_cnt) == scpu_pkg::CLEAR_LEN - 1) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (exec_fire) begin
        res_valid <= 1'b1;
        pc        <= pc_next;
        sp        <= sp_next;
        ra        <= ra_next;
        halted    <= halted_next;
      end else if (!result_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !result_valid && !s1_valid)
    else $error("transaction in flight during clearing pass");

  a_sp_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(sp) < scpu_pkg::STACK_DEPTH)
    else $error("stack pointer beyond stack depth");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted && $stable(pc) && $stable(sp) && $stable(ra))
    else $error("state changed after halt");

  a_stop_sets_halt: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && !halted && res_next.run_status != scpu_pkg::RUN_OK) |=> halted)
    else $error("exit or illegal opcode did not halt");

  a_halted_reports_exit: assert property (@(posedge clk) disable iff (rst)
    (exec_fire && halted) |=> result_valid
      && result.run_status == scpu_pkg::RUN_EXIT
      && result.print_kind == scpu_pkg::PRINT_NONE)
    else $error("halted transaction reported wrong status");

endmodule
